[hdl/adm_pkg.sv]
`default_nettype none

package adm_pkg;

    // parameter defaults
    localparam int TIME_BITS_DEF     = 32;
    localparam int POSITION_BITS_DEF = 16;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;

    // fire_duration + fire_direction + fire_duty
    localparam int FIRE_FIELDS_W = 26;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_ENABLE          = 3'd0;
    localparam reg_idx_t REG_MODE            = 3'd1;
    localparam reg_idx_t REG_POSITION_GAIN   = 3'd2;
    localparam reg_idx_t REG_POSITION_TARGET = 3'd3;
    localparam reg_idx_t REG_SWEEP_TIME_A    = 3'd4;
    localparam reg_idx_t REG_SWEEP_TIME_B    = 3'd5;
    localparam reg_idx_t REG_SWEEP_DUTY      = 3'd6;

    localparam logic [1:0] MODE_STOP   = 2'd0;
    localparam logic [1:0] MODE_POS    = 2'd1;
    localparam logic [1:0] MODE_SWEEP  = 2'd2;
    localparam logic [1:0] MODE_SINGLE = 2'd3;

    localparam logic [1:0] DIR_A = 2'd1;
    localparam logic [1:0] DIR_B = 2'd2;

    localparam logic       OP_UPDATE = 1'b0;
    localparam logic       OP_FIRE   = 1'b1;

    // 75.0 in Q8.8
    localparam logic signed [15:0] ACC_LIMIT_Q = 16'sd19200;

    // reset values
    localparam logic [15:0] GAIN_RESET         = 16'd128;
    localparam int          TARGET_RESET       = 800;
    localparam logic [31:0] SWEEP_TIME_RESET   = 32'd1000;
    localparam logic [7:0]  SWEEP_DUTY_RESET   = 8'd75;
    localparam logic [15:0] SINGLE_DUR_RESET   = 16'd500;

    typedef struct packed {
        logic        enable;
        logic [1:0]  mode;
        logic [15:0] gain;
        logic [31:0] sweep_time_a;
        logic [31:0] sweep_time_b;
        logic [7:0]  sweep_duty;
    } cfg_t;

    typedef struct packed {
        logic [7:0] duty;
        logic [1:0] dir;
    } drive_t;

endpackage

`default_nettype wire

[hdl/adm_regs.sv]
`default_nettype none

module adm_regs #(
    parameter int POSITION_BITS = adm_pkg::POSITION_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [adm_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [adm_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic      [adm_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                     pready,
    output adm_pkg::cfg_t                            cfg,
    output logic signed [POSITION_BITS-1:0]          target
);
    import adm_pkg::*;

    cfg_t                            cfg_reg;
    logic signed [POSITION_BITS-1:0] target_reg;
    reg_idx_t                        idx;
    logic                            wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[CFG_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable       <= 1'b0;
            cfg_reg.mode         <= MODE_STOP;
            cfg_reg.gain         <= GAIN_RESET;
            cfg_reg.sweep_time_a <= SWEEP_TIME_RESET;
            cfg_reg.sweep_time_b <= SWEEP_TIME_RESET;
            cfg_reg.sweep_duty   <= SWEEP_DUTY_RESET;
            target_reg           <= POSITION_BITS'(TARGET_RESET);
        end
        else if (wr_en)
        begin
            case (idx)
                REG_ENABLE:          cfg_reg.enable       <= pwdata[0];
                REG_MODE:            cfg_reg.mode         <= pwdata[1:0];
                REG_POSITION_GAIN:   cfg_reg.gain         <= pwdata[15:0];
                REG_POSITION_TARGET: target_reg           <= pwdata[POSITION_BITS-1:0];
                REG_SWEEP_TIME_A:    cfg_reg.sweep_time_a <= pwdata;
                REG_SWEEP_TIME_B:    cfg_reg.sweep_time_b <= pwdata;
                REG_SWEEP_DUTY:      cfg_reg.sweep_duty   <= pwdata[7:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ENABLE:          prdata = CFG_DATA_W'(cfg_reg.enable);
            REG_MODE:            prdata = CFG_DATA_W'(cfg_reg.mode);
            REG_POSITION_GAIN:   prdata = CFG_DATA_W'(cfg_reg.gain);
            REG_POSITION_TARGET: prdata = CFG_DATA_W'(target_reg);
            REG_SWEEP_TIME_A:    prdata = cfg_reg.sweep_time_a;
            REG_SWEEP_TIME_B:    prdata = cfg_reg.sweep_time_b;
            REG_SWEEP_DUTY:      prdata = CFG_DATA_W'(cfg_reg.sweep_duty);
            default:             prdata = '0;
        endcase
    end

    assign cfg    = cfg_reg;
    assign target = target_reg;

endmodule

`default_nettype wire

[hdl/adm_step.sv]
`default_nettype none

module adm_step #(
    parameter int TIME_BITS     = adm_pkg::TIME_BITS_DEF,
    parameter int POSITION_BITS = adm_pkg::POSITION_BITS_DEF
) (
    input  wire adm_pkg::cfg_t              cfg,
    input  wire logic signed [POSITION_BITS-1:0] target,
    input  wire logic                       opcode,
    input  wire logic [TIME_BITS-1:0]       now_ms,
    input  wire logic signed [POSITION_BITS-1:0] encoder_position,
    input  wire logic [15:0]                fire_duration,
    input  wire logic [1:0]                 fire_direction,
    input  wire logic [7:0]                 fire_duty,
    input  wire logic signed [15:0]         acc,
    input  wire logic [TIME_BITS-1:0]       interval_start,
    input  wire logic                       single_active,
    input  wire logic [15:0]                single_duration,
    input  wire adm_pkg::drive_t            drive,
    output logic signed [15:0]              acc_next,
    output logic [TIME_BITS-1:0]            interval_start_next,
    output logic                            single_active_next,
    output logic [15:0]                     single_duration_next,
    output adm_pkg::drive_t                 drive_next,
    output logic                            changed
);
    import adm_pkg::*;

    localparam int EW = POSITION_BITS + 1;
    localparam int PW = POSITION_BITS + 18;
    localparam int SW = POSITION_BITS + 19;
    localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic signed [EW-1:0] err;
    logic signed [PW-1:0] prod;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] lim_hi;
    logic signed [SW-1:0] lim_lo;
    logic signed [15:0]   acc_clamp;
    logic        [15:0]   mag;
    logic [TIME_BITS-1:0] diff;
    logic [CW-1:0]        diff_ext;
    logic [CW-1:0]        limit_ext;
    logic                 over;

    // position loop, exact Q8.8
    assign err    = EW'(target) - EW'(encoder_position);
    assign prod   = PW'(signed'({1'b0, cfg.gain})) * PW'(err);
    assign sum    = SW'(prod) + SW'(acc);
    assign lim_hi = SW'(ACC_LIMIT_Q);
    assign lim_lo = -SW'(ACC_LIMIT_Q);

    always_comb
    begin
        if (sum > lim_hi)
            acc_clamp = ACC_LIMIT_Q;
        else if (sum < lim_lo)
            acc_clamp = -ACC_LIMIT_Q;
        else
            acc_clamp = 16'(sum);
    end

    assign mag = acc_clamp[15] ? 16'(-acc_clamp) : 16'(acc_clamp);

    // one elapsed-time compare shared by sweep and single-fire
    assign diff     = now_ms - interval_start;
    assign diff_ext = CW'(diff);

    always_comb
    begin
        if (cfg.mode == MODE_SINGLE)
            limit_ext = CW'(single_duration);
        else if (drive.dir == DIR_A)
            limit_ext = CW'(cfg.sweep_time_a);
        else
            limit_ext = CW'(cfg.sweep_time_b);
    end

    assign over = diff_ext > limit_ext;

    always_comb
    begin
        acc_next             = acc;
        interval_start_next  = interval_start;
        single_active_next   = single_active;
        single_duration_next = single_duration;
        drive_next           = drive;
        changed              = 1'b0;

        if (opcode == OP_FIRE)
        begin
            single_duration_next = fire_duration;
            single_active_next   = 1'b1;
            interval_start_next  = now_ms;
            drive_next.duty      = fire_duty;
            drive_next.dir       = (fire_direction == DIR_A) ? DIR_A : DIR_B;
            changed              = 1'b1;
        end
        else if (!cfg.enable || cfg.mode == MODE_STOP)
        begin
            drive_next.duty = '0;
            drive_next.dir  = DIR_B;
            changed         = 1'b1;
        end
        else
        begin
            case (cfg.mode)
                MODE_POS:
                begin
                    acc_next        = acc_clamp;
                    drive_next.duty = mag[15:8];
                    drive_next.dir  = acc_clamp[15] ? DIR_A : DIR_B;
                    changed         = 1'b1;
                end
                MODE_SWEEP:
                begin
                    if (over)
                    begin
                        drive_next.duty     = cfg.sweep_duty;
                        drive_next.dir      = (drive.dir == DIR_A) ? DIR_B : DIR_A;
                        interval_start_next = now_ms;
                        changed             = 1'b1;
                    end
                end
                default:
                begin
                    if (single_active && over)
                    begin
                        drive_next.duty    = '0;
                        drive_next.dir     = DIR_B;
                        single_active_next = 1'b0;
                        changed            = 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/actuator_drive_mode_controller_unit.sv]
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: opcode; tdata: now_ms, encoder_position,
//                                   fire_duration, fire_direction, fire_duty
// m_*       out  m_tvalid/m_tready  tuser: drive_changed; tdata: duty, direction
// APB       in   psel/penable       registers at 4*index, pready tied high
//
// One beat per cycle sustained while m_tready is high. A beat is first captured in
// the input register, then the step logic (one 16 x (POSITION_BITS+1) multiply,
// clamp, one time compare) loads the result register and the drive state on the
// same edge. Asynchronous active-low reset; state returns to duty 0, direction B.
// A stalled result holds the pipe while the input register still takes one more
// beat.

module actuator_drive_mode_controller_unit #(
    parameter int TIME_BITS     = adm_pkg::TIME_BITS_DEF,
    parameter int POSITION_BITS = adm_pkg::POSITION_BITS_DEF,
    parameter int IN_W = ((TIME_BITS + POSITION_BITS + adm_pkg::FIRE_FIELDS_W + 7) / 8) * 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // now_ms, encoder_position, fire_duration[15:0], fire_direction[1:0], fire_duty[7:0]
    input  wire logic [IN_W-1:0]                 s_tdata,
    // opcode
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // duty[7:0], direction[9:8], zero fill [15:10]
    output logic [15:0]                          m_tdata,
    // drive_changed
    output logic                                 m_tuser,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [adm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [adm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [adm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready
);
    import adm_pkg::*;

    localparam int T = TIME_BITS;
    localparam int P = POSITION_BITS;

    cfg_t                  cfg;
    logic signed [P-1:0]   target;

    logic                  in_valid_reg;
    logic                  in_opcode_reg;
    logic [IN_W-1:0]       in_data_reg;
    logic                  advance;
    logic                  fire;

    logic [T-1:0]          f_now;
    logic signed [P-1:0]   f_enc;
    logic [15:0]           f_dur;
    logic [1:0]            f_dir;
    logic [7:0]            f_duty;

    logic signed [15:0]    acc_reg;
    logic signed [15:0]    acc_next;
    logic [T-1:0]          start_reg;
    logic [T-1:0]          start_next;
    logic                  active_reg;
    logic                  active_next;
    logic [15:0]           dur_reg;
    logic [15:0]           dur_next;
    drive_t                drive_reg;
    drive_t                drive_next;
    logic                  changed;
    logic                  out_valid_reg;
    logic                  changed_reg;

    adm_regs #(
        .POSITION_BITS (POSITION_BITS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .target  (target)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign f_now  = in_data_reg[T-1:0];
    assign f_enc  = in_data_reg[T+P-1:T];
    assign f_dur  = in_data_reg[T+P+15:T+P];
    assign f_dir  = in_data_reg[T+P+17:T+P+16];
    assign f_duty = in_data_reg[T+P+25:T+P+18];

    adm_step #(
        .TIME_BITS     (TIME_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .cfg                  (cfg),
        .target               (target),
        .opcode               (in_opcode_reg),
        .now_ms               (f_now),
        .encoder_position     (f_enc),
        .fire_duration        (f_dur),
        .fire_direction       (f_dir),
        .fire_duty            (f_duty),
        .acc                  (acc_reg),
        .interval_start       (start_reg),
        .single_active        (active_reg),
        .single_duration      (dur_reg),
        .drive                (drive_reg),
        .acc_next             (acc_next),
        .interval_start_next  (start_next),
        .single_active_next   (active_next),
        .single_duration_next (dur_next),
        .drive_next           (drive_next),
        .changed              (changed)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_opcode_reg <= s_tuser;
            in_data_reg   <= s_tdata;
        end
    end

    // drive state and result register load together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            start_reg      <= '0;
            active_reg     <= 1'b0;
            dur_reg        <= SINGLE_DUR_RESET;
            drive_reg.duty <= '0;
            drive_reg.dir  <= DIR_B;
            out_valid_reg  <= 1'b0;
            changed_reg    <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                acc_reg     <= acc_next;
                start_reg   <= start_next;
                active_reg  <= active_next;
                dur_reg     <= dur_next;
                drive_reg   <= drive_next;
                changed_reg <= changed;
            end
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = changed_reg;
    assign m_tdata  = {6'b0, drive_reg.dir, drive_reg.duty};

    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg <= ACC_LIMIT_Q) && (acc_reg >= -ACC_LIMIT_Q))
        else $error("velocity accumulator out of range");

    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        (drive_reg.dir == DIR_A) || (drive_reg.dir == DIR_B))
        else $error("drive direction not A or B");

    a_hold_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !changed) |=> (drive_reg == $past(drive_reg)) && !m_tuser)
        else $error("unchanged result altered the drive");

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipe");

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
    import adm_pkg::*;

    typedef struct packed {
        logic        opcode;
        logic [31:0] now_ms;
        logic [15:0] position;
        logic [15:0] fire_duration;
        logic [1:0]  fire_direction;
        logic [7:0]  fire_duty;
    } motor_cmd_t;

    typedef struct packed {
        logic       changed;
        logic [7:0] duty;
        logic [1:0] dir;
    } drive_beat_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // now_ms[31:0], encoder_position[47:32], fire_duration[63:48],
    // fire_direction[65:64], fire_duty[73:66], zero fill [79:74]
    logic [79:0] s_tdata;
    // opcode
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // duty[7:0], direction[9:8], zero fill [15:10]
    logic [15:0] m_tdata;
    // drive_changed
    logic        m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    actuator_drive_mode_controller_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // register shadow
    logic        en_q;
    logic [1:0]  mode_q;
    logic [15:0] gain_q;
    logic [15:0] target_q;
    logic [31:0] span_a;
    logic [31:0] span_b;
    logic [7:0]  sweep_duty_q;

    // drive state shadow
    longint      vel_acc;
    logic [31:0] mark_ms;
    bit          fire_armed;
    logic [15:0] fire_ms;
    logic [7:0]  duty_now;
    logic [1:0]  dir_now;

    drive_beat_t drive_expected[$];
    drive_beat_t want_beat;
    int          error_count = 0;
    bit          idle_on = 1'b1;
    int          result_hold = 0;
    int          rx_gap = 0;
    logic [31:0] ms_clock = 32'd0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= 40)
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic drive_beat_t predict_drive(input motor_cmd_t c);
        drive_beat_t r;
        longint      err;
        longint      acc;
        longint      mag;
        logic [31:0] elapsed;
        r.changed = 1'b0;
        elapsed = c.now_ms - mark_ms;
        if (c.opcode == OP_FIRE)
        begin
            fire_ms    = c.fire_duration;
            fire_armed = 1'b1;
            mark_ms    = c.now_ms;
            duty_now   = c.fire_duty;
            dir_now    = (c.fire_direction == DIR_A) ? DIR_A : DIR_B;
            r.changed  = 1'b1;
        end
        else if (!en_q || mode_q == MODE_STOP)
        begin
            duty_now  = 8'd0;
            dir_now   = DIR_B;
            r.changed = 1'b1;
        end
        else if (mode_q == MODE_POS)
        begin
            err = longint'($signed(target_q)) - longint'($signed(c.position));
            acc = vel_acc + longint'(gain_q) * err;
            if (acc > longint'(ACC_LIMIT_Q))
                acc = longint'(ACC_LIMIT_Q);
            if (acc < -longint'(ACC_LIMIT_Q))
                acc = -longint'(ACC_LIMIT_Q);
            vel_acc   = acc;
            mag       = (acc < 0) ? -acc : acc;
            duty_now  = 8'(mag >> 8);
            dir_now   = (acc < 0) ? DIR_A : DIR_B;
            r.changed = 1'b1;
        end
        else if (mode_q == MODE_SWEEP)
        begin
            if (dir_now == DIR_A)
            begin
                if (elapsed > span_a)
                begin
                    duty_now  = sweep_duty_q;
                    dir_now   = DIR_B;
                    mark_ms   = c.now_ms;
                    r.changed = 1'b1;
                end
            end
            else if (elapsed > span_b)
            begin
                duty_now  = sweep_duty_q;
                dir_now   = DIR_A;
                mark_ms   = c.now_ms;
                r.changed = 1'b1;
            end
        end
        else if (fire_armed && elapsed > {16'd0, fire_ms})
        begin
            duty_now   = 8'd0;
            dir_now    = DIR_B;
            fire_armed = 1'b0;
            r.changed  = 1'b1;
        end
        r.duty = duty_now;
        r.dir  = dir_now;
        return r;
    endfunction

    function automatic motor_cmd_t cmd_of(input logic op, input logic [31:0] now,
                                          input logic [15:0] pos, input logic [15:0] dur,
                                          input logic [1:0] dir, input logic [7:0] duty);
        motor_cmd_t c;
        c.opcode         = op;
        c.now_ms         = now;
        c.position       = pos;
        c.fire_duration  = dur;
        c.fire_direction = dir;
        c.fire_duty      = duty;
        return c;
    endfunction

    // well-formed stream: time mostly creeps forward, positions near the target
    function automatic motor_cmd_t make_cmd(input int fire_pct);
        motor_cmd_t c;
        c.opcode = ($urandom_range(0, 99) < fire_pct) ? OP_FIRE : OP_UPDATE;
        case ($urandom_range(0, 19))
            0:       ms_clock = $urandom();
            1:       ms_clock = ms_clock + $urandom_range(0, 100000);
            default: ms_clock = ms_clock + $urandom_range(0, 120);
        endcase
        c.now_ms = ms_clock;
        if ($urandom_range(0, 3) == 0)
            c.position = 16'($urandom());
        else
            c.position = target_q + 16'($urandom_range(0, 400)) - 16'd200;
        c.fire_duration = ($urandom_range(0, 4) == 0) ? 16'($urandom())
                                                       : 16'($urandom_range(0, 300));
        if ($urandom_range(0, 9) == 0)
            c.fire_direction = 2'($urandom_range(0, 3));
        else
            c.fire_direction = $urandom_range(0, 1) ? DIR_A : DIR_B;
        c.fire_duty = 8'($urandom());
        return c;
    endfunction

    function automatic logic [31:0] pick_span();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom();
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENABLE:          en_q         = value[0];
            REG_MODE:            mode_q       = value[1:0];
            REG_POSITION_GAIN:   gain_q       = value[15:0];
            REG_POSITION_TARGET: target_q     = value[15:0];
            REG_SWEEP_TIME_A:    span_a       = value;
            REG_SWEEP_TIME_B:    span_b       = value;
            REG_SWEEP_DUTY:      sweep_duty_q = value[7:0];
            default: ;
        endcase
    endtask

    task automatic send_cmd(input motor_cmd_t c);
        int gap;
        if (idle_on && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= c.opcode;
        s_tdata  <= {6'd0, c.fire_duty, c.fire_direction, c.fire_duration,
                     c.position, c.now_ms};
        do
            @(posedge clk);
        while (!s_tready);
        drive_expected.push_back(predict_drive(c));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (drive_expected.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // result side: random stalls, plus a long hold-off when a test asks for one
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (result_hold > 0)
            begin
                m_tready <= 1'b0;
                result_hold--;
            end
            else if (rx_gap > 0)
            begin
                m_tready <= 1'b0;
                rx_gap--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                rx_gap = $urandom_range(0, 11);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (drive_expected.size() == 0)
                report_mismatch("result beat with nothing pending", 32'(m_tdata), 32'd0);
            else
            begin
                want_beat = drive_expected.pop_front();
                if (m_tuser !== want_beat.changed)
                    report_mismatch("drive_changed", 32'(m_tuser), 32'(want_beat.changed));
                if (m_tdata[7:0] !== want_beat.duty)
                    report_mismatch("duty", 32'(m_tdata[7:0]), 32'(want_beat.duty));
                if (m_tdata[9:8] !== want_beat.dir)
                    report_mismatch("direction", 32'(m_tdata[9:8]), 32'(want_beat.dir));
                if (m_tdata[15:10] !== 6'd0)
                    report_mismatch("tdata fill", 32'(m_tdata[15:10]), 32'd0);
            end
        end
    end

    task automatic test_reset_values();
        // disabled after reset, but a fire still goes through
        send_cmd(cmd_of(OP_UPDATE, 32'd5, 16'd0, 16'd0, DIR_B, 8'd0));
        send_cmd(cmd_of(OP_FIRE, 32'd10, 16'd0, 16'd0, DIR_A, 8'd255));
        wait_drained();
        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_MODE, 32'(MODE_POS));
        // reset gain and target; both clamp
        send_cmd(cmd_of(OP_UPDATE, 32'd20, 16'd0, 16'd0, DIR_B, 8'd0));
        send_cmd(cmd_of(OP_UPDATE, 32'd21, 16'h7FFF, 16'd0, DIR_B, 8'd0));
    endtask

    task automatic test_stop_modes();
        wait_drained();
        write_reg(REG_MODE, 32'(MODE_STOP));
        send_cmd(cmd_of(OP_UPDATE, 32'd30, 16'd0, 16'd0, DIR_A, 8'd9));
        wait_drained();
        write_reg(REG_ENABLE, 32'd0);
        write_reg(REG_MODE, 32'(MODE_SWEEP));
        send_cmd(cmd_of(OP_UPDATE, 32'd40, 16'd0, 16'd0, DIR_A, 8'd9));
    endtask

    task automatic test_position_loop();
        wait_drained();
        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_MODE, 32'(MODE_POS));
        write_reg(REG_POSITION_GAIN, 32'd0);
        send_cmd(cmd_of(OP_UPDATE, 32'd50, 16'd0, 16'd0, DIR_B, 8'd0));
        wait_drained();
        write_reg(REG_POSITION_GAIN, 32'd65535);
        write_reg(REG_POSITION_TARGET, 32'h8000);
        send_cmd(cmd_of(OP_UPDATE, 32'd51, 16'h7FFF, 16'd0, DIR_B, 8'd0));
        wait_drained();
        write_reg(REG_POSITION_TARGET, 32'h7FFF);
        send_cmd(cmd_of(OP_UPDATE, 32'd52, 16'h8000, 16'd0, DIR_B, 8'd0));
        wait_drained();
        write_reg(REG_POSITION_GAIN, 32'd1);
        write_reg(REG_POSITION_TARGET, 32'd0);
        // small accumulator: fraction dropped, on both signs
        send_cmd(cmd_of(OP_UPDATE, 32'd53, 16'd19000, 16'd0, DIR_B, 8'd0));
        send_cmd(cmd_of(OP_UPDATE, 32'd54, 16'd300, 16'd0, DIR_B, 8'd0));
        send_cmd(cmd_of(OP_UPDATE, 32'd55, 16'hFE0C, 16'd0, DIR_B, 8'd0));
    endtask

    task automatic test_sweep();
        wait_drained();
        write_reg(REG_MODE, 32'(MODE_SWEEP));
        write_reg(REG_SWEEP_TIME_A, 32'd10);
        write_reg(REG_SWEEP_TIME_B, 32'd20);
        write_reg(REG_SWEEP_DUTY, 32'd200);
        send_cmd(cmd_of(OP_UPDATE, 32'd25, 16'd0, 16'd0, DIR_B, 8'd0));
        send_cmd(cmd_of(OP_UPDATE, 32'd31, 16'd0, 16'd0, DIR_B, 8'd0));
        send_cmd(cmd_of(OP_UPDATE, 32'd42, 16'd0, 16'd0, DIR_B, 8'd0));
        // time goes backwards: the wrapped difference is huge
        send_cmd(cmd_of(OP_UPDATE, 32'd37, 16'd0, 16'd0, DIR_B, 8'd0));
        wait_drained();
        write_reg(REG_SWEEP_TIME_A, 32'hFFFF_FFFF);
        send_cmd(cmd_of(OP_UPDATE, 32'h8000_0000, 16'd0, 16'd0, DIR_B, 8'd0));
    endtask

    task automatic test_single_fire();
        wait_drained();
        write_reg(REG_MODE, 32'(MODE_SINGLE));
        send_cmd(cmd_of(OP_UPDATE, 32'd37, 16'd0, 16'd0, DIR_B, 8'd0));
        send_cmd(cmd_of(OP_UPDATE, 32'd38, 16'd0, 16'd0, DIR_B, 8'd0));
        send_cmd(cmd_of(OP_UPDATE, 32'd1000, 16'd0, 16'd0, DIR_B, 8'd0));
        // direction codes other than A fall back to B
        send_cmd(cmd_of(OP_FIRE, 32'hFFFF_FF00, 16'd0, 16'hFFFF, 2'd0, 8'd0));
        send_cmd(cmd_of(OP_FIRE, 32'hFFFF_FFF0, 16'd0, 16'd100, 2'd3, 8'd128));
        send_cmd(cmd_of(OP_FIRE, 32'hFFFF_FFF0, 16'd0, 16'd100, DIR_A, 8'd7));
        send_cmd(cmd_of(OP_UPDATE, 32'h50, 16'd0, 16'd0, DIR_B, 8'd0));
        send_cmd(cmd_of(OP_UPDATE, 32'h55, 16'd0, 16'd0, DIR_B, 8'd0));
        ms_clock = 32'h55;
    endtask

    task automatic run_random_phase(input logic [1:0] mode, input int count);
        int fire_pct;
        wait_drained();
        write_reg(REG_ENABLE, 32'($urandom_range(0, 9) != 0));
        write_reg(REG_MODE, 32'(mode));
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_POSITION_GAIN, $urandom_range(0, 65535));
        else
            write_reg(REG_POSITION_GAIN, $urandom_range(0, 600));
        write_reg(REG_POSITION_TARGET, $urandom_range(0, 65535));
        write_reg(REG_SWEEP_TIME_A, pick_span());
        write_reg(REG_SWEEP_TIME_B, pick_span());
        write_reg(REG_SWEEP_DUTY, $urandom_range(0, 255));
        fire_pct = (mode == MODE_SINGLE) ? 20 : 5;
        repeat (count) send_cmd(make_cmd(fire_pct));
    endtask

    task automatic test_random_phases();
        run_random_phase(MODE_POS, 130);
        run_random_phase(MODE_SWEEP, 130);
        run_random_phase(MODE_SINGLE, 130);
        run_random_phase(MODE_STOP, 130);
        ms_clock = 32'hFFFF_F000;
        run_random_phase(MODE_POS, 130);
        run_random_phase(MODE_SWEEP, 130);
        run_random_phase(MODE_SINGLE, 130);
        run_random_phase(2'($urandom_range(0, 3)), 130);
    endtask

    task automatic test_backpressure();
        wait_drained();
        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_MODE, 32'(MODE_POS));
        // results blocked long enough for the pipe to fill and push back
        result_hold = 200;
        repeat (50) send_cmd(make_cmd(10));
        wait_drained();
        repeat (20) send_cmd(make_cmd(10));
    endtask

    task automatic test_quiet_tail();
        wait_drained();
        idle_on = 1'b0;
        run_random_phase(2'($urandom_range(0, 3)), 60);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        en_q         = 1'b0;
        mode_q       = MODE_STOP;
        gain_q       = GAIN_RESET;
        target_q     = 16'(TARGET_RESET);
        span_a       = SWEEP_TIME_RESET;
        span_b       = SWEEP_TIME_RESET;
        sweep_duty_q = SWEEP_DUTY_RESET;
        vel_acc      = 0;
        mark_ms      = 32'd0;
        fire_armed   = 1'b0;
        fire_ms      = SINGLE_DUR_RESET;
        duty_now     = 8'd0;
        dir_now      = DIR_B;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_stop_modes();
        test_position_loop();
        test_sweep();
        test_single_fire();
        test_random_phases();
        test_backpressure();
        test_quiet_tail();

        wait_drained();
        repeat (10) @(posedge clk);
        if (error_count == 0 && drive_expected.size() == 0)
            $display("** actuator_drive_mode_controller_unit: PASSED **");
        else
            $display("** actuator_drive_mode_controller_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("** actuator_drive_mode_controller_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

[actuator_drive_mode_controller_unit.f]
hdl/adm_pkg.sv
hdl/adm_regs.sv
hdl/adm_step.sv
hdl/actuator_drive_mode_controller_unit.sv
tb/testbench.sv
